FILE: rtl/core/cntp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cntp_pkg
// Shared constants, widths and arithmetic helpers for the colour normal tail
// score core.
// ----------------------------------------------------------------------------
package cntp_pkg;

    localparam int RECIP_FRAC_BITS = 12;
    localparam int OUT_FRAC_BITS   = 15;

    // internal fixed point
    localparam int FB = 24;
    localparam logic [FB:0]   ONE  = (FB+1)'(1) << FB;
    localparam logic [FB-1:0] HALF = FB'(1) << (FB - 1);

    localparam int NUM_CH = 3;

    // field and internal widths
    localparam int PIX_W  = 8;
    localparam int INV_W  = 16;
    localparam int ZQ_W   = PIX_W + INV_W;
    localparam int ZS_W   = RECIP_FRAC_BITS + 3;     // zq below 8.0
    localparam int X_W    = 27;                      // x below 5.66
    localparam int DEN_W  = 26;                      // den below 2.86
    localparam int T_W    = FB + 1;                  // t up to 1.0
    localparam int S_W    = 28;                      // signed poly value
    localparam int P_W    = 26;                      // clamped poly
    localparam int H_W    = FB + 1;                  // exp value up to 1.0
    localparam int U_W    = 30;
    localparam int V_W    = 30;
    localparam int K_W    = V_W - FB;
    localparam int TAIL_W = FB;                      // tail up to 0.5
    localparam int SUM_W  = TAIL_W + 2;
    localparam int OUT_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // pipeline depths
    localparam int DIV_STEPS   = T_W;
    localparam int POLY_STEPS  = 5;
    localparam int TAYLOR_N    = 9;
    localparam int BRANCH_LAT  = 1 + DIV_STEPS + POLY_STEPS;
    localparam int LANE_LAT    = 2 + BRANCH_LAT + 1;
    localparam int PIPE_LAT    = LANE_LAT + 1;

    // constants at Q.24
    localparam logic [23:0] K_INVSQRT2 = 24'd11863283;
    localparam logic [22:0] K_P        = 23'd5496067;
    localparam logic [24:0] K_LOG2E    = 25'd24204406;
    localparam logic [23:0] K_LN2      = 24'd11629080;

    localparam logic signed [S_W-1:0] K_A1 = S_W'(4275331);
    localparam logic signed [S_W-1:0] K_A2 = -S_W'(4773063);
    localparam logic signed [S_W-1:0] K_A3 = S_W'(23847365);
    localparam logic signed [S_W-1:0] K_A4 = -S_W'(24379845);
    localparam logic signed [S_W-1:0] K_A5 = S_W'(17807428);

    // coefficients in Horner order
    localparam logic signed [S_W-1:0] POLY_COEF [POLY_STEPS] =
        '{K_A5, K_A4, K_A3, K_A2, K_A1};

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MEAN_BLUE  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MEAN_GREEN = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MEAN_RED   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_INV_BLUE   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INV_GREEN  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_INV_RED    = 3'd5;

    localparam logic [PIX_W-1:0] MEAN_RST = '0;
    localparam logic [INV_W-1:0] INV_RST  = 16'd4096;

    // signed times unsigned, rounded half away from zero at Q.24
    function automatic logic signed [S_W-1:0] mul_s(
        input logic signed [S_W-1:0] a,
        input logic        [T_W-1:0] t
    );
        logic [S_W-1:0]     mag;
        logic [S_W+T_W-1:0] prod;
        logic [S_W+T_W-1:0] rnd;
        logic [S_W-1:0]     res;
        mag  = a[S_W-1] ? S_W'(-a) : S_W'(a);
        prod = (S_W+T_W)'(mag) * (S_W+T_W)'(t);
        rnd  = (prod + (S_W+T_W)'(HALF)) >> FB;
        res  = S_W'(rnd);
        return a[S_W-1] ? -$signed(res) : $signed(res);
    endfunction

endpackage

FILE: rtl/core/cntp_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cntp_recip
// Pipelined rounded reciprocal t = round(2^48 / den), one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module cntp_recip (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [cntp_pkg::DEN_W-1:0] i_den,
    output logic [cntp_pkg::T_W-1:0]   o_t
);
    import cntp_pkg::*;

    logic [DEN_W-1:0] r_rem [DIV_STEPS];
    logic [DEN_W-1:0] r_den [DIV_STEPS];
    logic [T_W-1:0]   r_low [DIV_STEPS];
    logic [T_W-1:0]   r_q   [DIV_STEPS];

    // numerator is 2^48 + den/2: top part 2^23, low 25 bits den/2
    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++) begin : g_step
            logic [DEN_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [T_W-1:0]   low_in;
            logic [T_W-1:0]   q_in;
            logic [DEN_W:0]   sh;
            logic             take;
            if (j == 0) begin : g_first
                assign rem_in = DEN_W'(1) << (FB - 1);
                assign den_in = i_den;
                assign low_in = T_W'(i_den >> 1);
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign den_in = r_den[j-1];
                assign low_in = r_low[j-1];
                assign q_in   = r_q[j-1];
            end
            assign sh   = {rem_in, low_in[T_W-1-j]};
            assign take = sh >= {1'b0, den_in};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= take ? DEN_W'(sh - {1'b0, den_in}) : DEN_W'(sh);
                    r_den[j] <= den_in;
                    r_low[j] <= low_in;
                    r_q[j]   <= {q_in[T_W-2:0], take};
                end
            end
        end
    endgenerate

    assign o_t = r_q[DIV_STEPS-1];

endmodule

FILE: rtl/core/cntp_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cntp_exp
// Pipelined exp(-x*x): power of two split plus a ninth order Taylor series
// for the fraction, three stages per term.
// ----------------------------------------------------------------------------
module cntp_exp (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [cntp_pkg::X_W-1:0] i_x,
    output logic [cntp_pkg::H_W-1:0] o_e
);
    import cntp_pkg::*;

    logic [2*X_W-1:0]  w_xx;
    logic [U_W+24:0]   w_uv;
    logic [47:0]       w_fg;
    logic [U_W-1:0]    r_u;
    logic [V_W-1:0]    r_v;
    logic [FB-1:0]     r_g;
    logic [K_W-1:0]    r_k;

    logic [2*FB:0]     r_gh  [TAYLOR_N];
    logic [FB-1:0]     r_ga  [TAYLOR_N];
    logic [K_W-1:0]    r_ka  [TAYLOR_N];
    logic [H_W-1:0]    r_y   [TAYLOR_N];
    logic [H_W-1:0]    r_q0  [TAYLOR_N];
    logic [FB-1:0]     r_gb  [TAYLOR_N];
    logic [K_W-1:0]    r_kb  [TAYLOR_N];
    logic [H_W-1:0]    r_h   [TAYLOR_N];
    logic [FB-1:0]     r_gc  [TAYLOR_N];
    logic [K_W-1:0]    r_kc  [TAYLOR_N];

    logic [H_W-1:0]    r_e;
    logic [H_W:0]      w_rnd;
    logic [H_W-1:0]    w_e;
    logic [K_W-1:0]    w_k;

    assign w_xx = (2*X_W)'(i_x) * (2*X_W)'(i_x);
    assign w_uv = (U_W+25)'(r_u) * (U_W+25)'(K_LOG2E);
    assign w_fg = 48'(r_v[FB-1:0]) * 48'(K_LN2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= U_W'((w_xx + (2*X_W)'(HALF)) >> FB);
            r_v <= V_W'((w_uv + (U_W+25)'(HALF)) >> FB);
            r_g <= FB'((w_fg + 48'(HALF)) >> FB);
            r_k <= r_v[V_W-1:FB];
        end
    end

    genvar i;
    generate
        for (i = 0; i < TAYLOR_N; i++) begin : g_term
            localparam int N = TAYLOR_N - i;
            localparam logic [32:0] M = 33'((64'd1 << 32) / N);
            logic [H_W-1:0]  h_in;
            logic [FB-1:0]   g_in;
            logic [K_W-1:0]  k_in;
            logic [H_W-1:0]  y;
            logic [H_W+32:0] yp;
            logic [H_W-1:0]  rem;
            logic [H_W-1:0]  q;
            if (i == 0) begin : g_first
                assign h_in = ONE;
                assign g_in = r_g;
                assign k_in = r_k;
            end else begin : g_next
                assign h_in = r_h[i-1];
                assign g_in = r_gc[i-1];
                assign k_in = r_kc[i-1];
            end
            assign y   = H_W'((r_gh[i] + (2*FB+1)'(N) * (2*FB+1)'(HALF)) >> FB);
            assign yp  = (H_W+33)'(y) * (H_W+33)'(M);
            // reciprocal estimate is at most one low, fix with one compare
            assign rem = r_y[i] - H_W'(r_q0[i] * H_W'(N));
            assign q   = r_q0[i] + H_W'(rem >= H_W'(N));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_gh[i] <= (2*FB+1)'(g_in) * (2*FB+1)'(h_in);
                    r_ga[i] <= g_in;
                    r_ka[i] <= k_in;
                    r_y[i]  <= y;
                    r_q0[i] <= H_W'(yp >> 32);
                    r_gb[i] <= r_ga[i];
                    r_kb[i] <= r_ka[i];
                    r_h[i]  <= ONE - q;
                    r_gc[i] <= r_gb[i];
                    r_kc[i] <= r_kb[i];
                end
            end
        end
    endgenerate

    // integer part of the exponent as a rounded right shift
    assign w_k   = r_kc[TAYLOR_N-1];
    assign w_rnd = (H_W+1)'(r_h[TAYLOR_N-1]) + (((H_W+1)'(1) << w_k) >> 1);

    always_comb begin
        if (w_k >= K_W'(25)) begin
            w_e = '0;
        end else if (w_k == '0) begin
            w_e = r_h[TAYLOR_N-1];
        end else begin
            w_e = H_W'(w_rnd >> w_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= w_e;
        end
    end

    assign o_e = r_e;

endmodule

FILE: rtl/core/cntp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cntp_lane
// One colour channel: |z| from mean and reciprocal deviation, then the
// polynomial and exponential branches and the channel tail.
// ----------------------------------------------------------------------------
module cntp_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [cntp_pkg::PIX_W-1:0]  i_pixel,
    input  logic [cntp_pkg::PIX_W-1:0]  i_mean,
    input  logic [cntp_pkg::INV_W-1:0]  i_inv,
    output logic [cntp_pkg::TAIL_W-1:0] o_tail
);
    import cntp_pkg::*;

    logic [PIX_W-1:0]      w_d;
    logic [ZQ_W-1:0]       r_zq;
    logic [ZS_W+23:0]      w_zk;
    logic [X_W-1:0]        r_x;
    logic                  r_sat;
    logic                  r_sat_d [BRANCH_LAT];
    logic [X_W+22:0]       w_xp;
    logic [DEN_W-1:0]      r_den;
    logic [T_W-1:0]        w_t;
    logic [S_W-1:0]        r_s [POLY_STEPS];
    logic [T_W-1:0]        r_t [POLY_STEPS-1];
    logic [H_W-1:0]        w_e;
    logic [P_W-1:0]        w_poly;
    logic [P_W+H_W-1:0]    w_pe;
    logic [P_W+H_W-1:0]    w_tl;
    logic [TAIL_W-1:0]     r_tail;

    assign w_d = (i_pixel >= i_mean) ? i_pixel - i_mean : i_mean - i_pixel;

    // x = zq * 2^(24-R) / sqrt2, narrowed before the multiply
    assign w_zk = (ZS_W+24)'(r_zq[ZS_W-1:0]) * (ZS_W+24)'(K_INVSQRT2);
    assign w_xp = (X_W+23)'(r_x) * (X_W+23)'(K_P);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zq    <= ZQ_W'(w_d) * ZQ_W'(i_inv);
            r_sat   <= r_zq >= (ZQ_W'(8) << RECIP_FRAC_BITS);
            r_x     <= X_W'((w_zk + ((ZS_W+24)'(1) << (RECIP_FRAC_BITS - 1)))
                            >> RECIP_FRAC_BITS);
            r_den   <= DEN_W'(ONE) + DEN_W'((w_xp + (X_W+23)'(HALF)) >> FB);
        end
    end

    genvar k;
    generate
        for (k = 0; k < BRANCH_LAT; k++) begin : g_sat
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sat_d[k] <= (k == 0) ? r_sat : r_sat_d[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    cntp_recip u_recip (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_den (r_den),
        .o_t   (w_t)
    );

    cntp_exp u_exp (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_x   (r_x),
        .o_e   (w_e)
    );

    // horner steps, t carried alongside
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= mul_s(POLY_COEF[0], w_t) + POLY_COEF[1];
            r_t[0] <= w_t;
            for (int p = 1; p < POLY_STEPS - 1; p++) begin
                r_s[p] <= mul_s($signed(r_s[p-1]), r_t[p-1]) + POLY_COEF[p+1];
                r_t[p] <= r_t[p-1];
            end
            r_s[POLY_STEPS-1] <= mul_s($signed(r_s[POLY_STEPS-2]), r_t[POLY_STEPS-2]);
        end
    end

    assign w_poly = r_s[POLY_STEPS-1][S_W-1] ? '0 : r_s[POLY_STEPS-1][P_W-1:0];
    assign w_pe   = (P_W+H_W)'(w_poly) * (P_W+H_W)'(w_e);
    assign w_tl   = (w_pe + (P_W+H_W)'(ONE)) >> (FB + 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat_d[BRANCH_LAT-1]) begin
                r_tail <= '0;
            end else if (w_tl > (P_W+H_W)'(HALF)) begin
                r_tail <= HALF;
            end else begin
                r_tail <= TAIL_W'(w_tl);
            end
        end
    end

    assign o_tail = r_tail;

endmodule

FILE: rtl/core/colour_normal_tail_pvalue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colour_normal_tail_pvalue_core
// Per-pixel sum of the three channel normal tails, Q1.15 result.
// ----------------------------------------------------------------------------
//  channel   signals                                   dir
//  pixel     i_in_valid / o_in_ready, i_pixel_*        in
//  score     o_out_valid / i_out_ready, o_tail_sum     out
//  config    i_cfg_we, i_cfg_index, i_cfg_data         in
//
//  one word per clock unless stalled; the 25 step reciprocal and the nine
//  term exponential pipelines run side by side in each lane
//  the whole pipeline advances unless a finished word sits unread at the
//  output, so a stalled consumer holds the input side only then
//  reset clears valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module colour_normal_tail_pvalue_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [cntp_pkg::PIX_W-1:0]  i_pixel_blue,
    input  logic [cntp_pkg::PIX_W-1:0]  i_pixel_green,
    input  logic [cntp_pkg::PIX_W-1:0]  i_pixel_red,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [cntp_pkg::OUT_W-1:0]  o_tail_sum,
    input  logic                       i_cfg_we,
    input  logic [cntp_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [cntp_pkg::CFG_W-1:0]  i_cfg_data
);
    import cntp_pkg::*;

    logic [PIX_W-1:0]  r_mean [NUM_CH];
    logic [INV_W-1:0]  r_inv  [NUM_CH];
    logic [PIX_W-1:0]  w_pix  [NUM_CH];
    logic [TAIL_W-1:0] w_tail [NUM_CH];
    logic [PIPE_LAT-1:0] r_vld;
    logic              w_en;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_rnd;
    logic [OUT_W-1:0]  r_out;

    assign w_en       = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_mean[c] <= MEAN_RST;
                r_inv[c]  <= INV_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MEAN_BLUE:  r_mean[0] <= i_cfg_data[PIX_W-1:0];
                CFG_MEAN_GREEN: r_mean[1] <= i_cfg_data[PIX_W-1:0];
                CFG_MEAN_RED:   r_mean[2] <= i_cfg_data[PIX_W-1:0];
                CFG_INV_BLUE:   r_inv[0]  <= i_cfg_data;
                CFG_INV_GREEN:  r_inv[1]  <= i_cfg_data;
                CFG_INV_RED:    r_inv[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    assign w_pix[0] = i_pixel_blue;
    assign w_pix[1] = i_pixel_green;
    assign w_pix[2] = i_pixel_red;

    genvar c;
    generate
        for (c = 0; c < NUM_CH; c++) begin : g_lane
            cntp_lane u_lane (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_pixel (w_pix[c]),
                .i_mean  (r_mean[c]),
                .i_inv   (r_inv[c]),
                .o_tail  (w_tail[c])
            );
        end
    endgenerate

    // merge lanes, round to output precision, saturate
    assign w_sum = SUM_W'(w_tail[0]) + SUM_W'(w_tail[1]) + SUM_W'(w_tail[2]);
    assign w_rnd = (w_sum + (SUM_W'(1) << (FB - OUT_FRAC_BITS - 1)))
                   >> (FB - OUT_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= (w_rnd > SUM_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(w_rnd);
        end
    end

    assign o_out_valid = r_vld[PIPE_LAT-1];
    assign o_tail_sum  = r_out;

endmodule
